### src/msrq_pkg.sv
package msrq_pkg;

    localparam int DEF_MAX_SLOTS      = 16;
    localparam int DEF_MAX_SLOT_BYTES = 32;

    // fixed field widths
    localparam int LEN_W     = 6;
    localparam int SC_W      = 5;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = 1'd1;

    localparam logic [SC_W-1:0]  RST_SLOT_COUNT = 5'd16;
    localparam logic [LEN_W-1:0] RST_SLOT_BYTES = 6'd32;

    localparam logic OP_SEND = 1'b0;
    localparam logic OP_RECV = 1'b1;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_FULL     = 2'd1,
        STS_TOO_LONG = 2'd2,
        STS_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEN,
        ST_STREAM
    } t_state;

    typedef struct packed {
        logic pay_we;
        logic pay_re;
        logic len_we;
        logic len_re;
    } t_mem_ctl;

endpackage

### src/message_slot_ring_queue.sv
// Mailbox of fixed message slots used as a ring. A send streams at most one
// byte per transfer with a last flag; its last transfer yields one result
// (stored, queue full, or too long). A receive is accepted, then fetches the
// slot length from the length memory, then gives one result per cycle (one
// per byte, or one for an empty message) read from the single payload
// memory read port, with output stall holding the stream. A receive on an
// empty queue gives its result in the cycle after it is accepted. No
// input is taken while a receive streams.
module message_slot_ring_queue
    import msrq_pkg::*;
#(
    parameter int MAX_SLOTS      = DEF_MAX_SLOTS,
    parameter int MAX_SLOT_BYTES = DEF_MAX_SLOT_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_opcode,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_byte_present,
    input  logic                 i_end_of_message,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_status,
    output logic [7:0]           o_out_byte,
    output logic                 o_out_byte_valid,
    output logic                 o_out_last,
    output logic [LEN_W-1:0]     o_message_length
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int DEPTH  = MAX_SLOTS * MAX_SLOT_BYTES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_mem_ctl          mem_ctl;
    logic [ADDR_W-1:0] pay_waddr;
    logic [7:0]        pay_wdata;
    logic [ADDR_W-1:0] pay_raddr;
    logic [7:0]        pay_rdata;
    logic [SLOT_W-1:0] len_waddr;
    logic [LEN_W-1:0]  len_wdata;
    logic [SLOT_W-1:0] len_raddr;
    logic [LEN_W-1:0]  len_rdata;

    msrq_ctrl #(
        .MAX_SLOTS      (MAX_SLOTS),
        .MAX_SLOT_BYTES (MAX_SLOT_BYTES)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_data_byte      (i_data_byte),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_out_byte       (o_out_byte),
        .o_out_byte_valid (o_out_byte_valid),
        .o_out_last       (o_out_last),
        .o_message_length (o_message_length),
        .o_ctl            (mem_ctl),
        .o_pay_waddr      (pay_waddr),
        .o_pay_wdata      (pay_wdata),
        .o_pay_raddr      (pay_raddr),
        .i_pay_rdata      (pay_rdata),
        .o_len_waddr      (len_waddr),
        .o_len_wdata      (len_wdata),
        .o_len_raddr      (len_raddr),
        .i_len_rdata      (len_rdata)
    );

    msrq_store #(
        .MAX_SLOTS      (MAX_SLOTS),
        .MAX_SLOT_BYTES (MAX_SLOT_BYTES)
    ) u_store (
        .i_clk       (i_clk),
        .i_ctl       (mem_ctl),
        .i_pay_waddr (pay_waddr),
        .i_pay_wdata (pay_wdata),
        .i_pay_raddr (pay_raddr),
        .o_pay_rdata (pay_rdata),
        .i_len_waddr (len_waddr),
        .i_len_wdata (len_wdata),
        .i_len_raddr (len_raddr),
        .o_len_rdata (len_rdata)
    );

endmodule

### src/msrq_store.sv
module msrq_store
    import msrq_pkg::*;
#(
    parameter int MAX_SLOTS      = DEF_MAX_SLOTS,
    parameter int MAX_SLOT_BYTES = DEF_MAX_SLOT_BYTES,
    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
    localparam int DEPTH  = MAX_SLOTS * MAX_SLOT_BYTES,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  t_mem_ctl          i_ctl,
    input  logic [ADDR_W-1:0] i_pay_waddr,
    input  logic [7:0]        i_pay_wdata,
    input  logic [ADDR_W-1:0] i_pay_raddr,
    output logic [7:0]        o_pay_rdata,
    input  logic [SLOT_W-1:0] i_len_waddr,
    input  logic [LEN_W-1:0]  i_len_wdata,
    input  logic [SLOT_W-1:0] i_len_raddr,
    output logic [LEN_W-1:0]  o_len_rdata
);

    logic [7:0]       r_pay_mem [DEPTH];
    logic [LEN_W-1:0] r_len_mem [MAX_SLOTS];
    logic [7:0]       r_pay_rdata;
    logic [LEN_W-1:0] r_len_rdata;

    // read data holds while the port is not enabled
    always_ff @(posedge i_clk) begin
        if (i_ctl.pay_we) begin
            r_pay_mem[i_pay_waddr] <= i_pay_wdata;
        end
        if (i_ctl.pay_re) begin
            r_pay_rdata <= r_pay_mem[i_pay_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.len_we) begin
            r_len_mem[i_len_waddr] <= i_len_wdata;
        end
        if (i_ctl.len_re) begin
            r_len_rdata <= r_len_mem[i_len_raddr];
        end
    end

    assign o_pay_rdata = r_pay_rdata;
    assign o_len_rdata = r_len_rdata;

endmodule

### src/msrq_ctrl.sv
module msrq_ctrl
    import msrq_pkg::*;
#(
    parameter int MAX_SLOTS      = DEF_MAX_SLOTS,
    parameter int MAX_SLOT_BYTES = DEF_MAX_SLOT_BYTES,
    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
    localparam int DEPTH  = MAX_SLOTS * MAX_SLOT_BYTES,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1),
    localparam int BI_W   = (MAX_SLOT_BYTES > 1) ? $clog2(MAX_SLOT_BYTES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_opcode,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_byte_present,
    input  logic                 i_end_of_message,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_status,
    output logic [7:0]           o_out_byte,
    output logic                 o_out_byte_valid,
    output logic                 o_out_last,
    output logic [LEN_W-1:0]     o_message_length,
    output t_mem_ctl             o_ctl,
    output logic [ADDR_W-1:0]    o_pay_waddr,
    output logic [7:0]           o_pay_wdata,
    output logic [ADDR_W-1:0]    o_pay_raddr,
    input  logic [7:0]           i_pay_rdata,
    output logic [SLOT_W-1:0]    o_len_waddr,
    output logic [LEN_W-1:0]     o_len_wdata,
    output logic [SLOT_W-1:0]    o_len_raddr,
    input  logic [LEN_W-1:0]     i_len_rdata
);

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_ws, n_ws;
    logic [SLOT_W-1:0] r_rs, n_rs;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [LEN_W-1:0]  r_staged, n_staged;
    logic              r_ovf, n_ovf;
    logic [SC_W-1:0]   r_slot_count;
    logic [LEN_W-1:0]  r_slot_bytes;
    logic [LEN_W-1:0]  r_rlen, n_rlen;
    logic [BI_W-1:0]   r_idx, n_idx;
    logic              r_out_valid, n_out_valid;
    t_status           r_status, n_status;
    logic              r_byte_sel, n_byte_sel;
    logic              r_last, n_last;
    logic [LEN_W-1:0]  r_out_len, n_out_len;

    logic [CNT_W-1:0]  eff_slots;
    logic [LEN_W:0]    eff_bytes;
    logic              full;
    logic              fits;
    logic              adv;
    logic              in_stall;
    logic              accept;
    logic              stream_last;
    logic [LEN_W-1:0]  rlen_clamped;
    logic [SLOT_W-1:0] ws_next;
    logic [SLOT_W-1:0] rs_next;

    assign eff_slots = (r_slot_count == '0) ? CNT_W'(1) :
                       ((int'(r_slot_count) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) :
                        CNT_W'(r_slot_count));
    assign eff_bytes = (int'(r_slot_bytes) > MAX_SLOT_BYTES) ? (LEN_W+1)'(MAX_SLOT_BYTES) :
                       {1'b0, r_slot_bytes};

    assign full   = r_count >= eff_slots;
    assign fits   = {1'b0, r_staged} < eff_bytes;
    assign adv    = !r_out_valid || !i_out_stall;

    // items that produce a result wait for the output register to free up
    assign in_stall = (r_state != ST_IDLE) ||
                      (r_out_valid && i_out_stall &&
                       (i_opcode == OP_RECV || i_end_of_message));
    assign accept   = i_in_valid && !in_stall;

    assign rlen_clamped = (int'(i_len_rdata) > MAX_SLOT_BYTES) ? LEN_W'(MAX_SLOT_BYTES) :
                          i_len_rdata;
    assign stream_last  = (r_rlen == '0) ||
                          ((LEN_W+1)'(r_idx) + (LEN_W+1)'(1) == {1'b0, r_rlen});

    assign ws_next = (int'(r_ws) + 1 >= int'(eff_slots)) ? '0 : SLOT_W'(r_ws + 1'b1);
    assign rs_next = (int'(r_rs) + 1 >= int'(eff_slots)) ? '0 : SLOT_W'(r_rs + 1'b1);

    assign o_pay_waddr = ADDR_W'(int'(r_ws) * MAX_SLOT_BYTES + int'(r_staged));
    assign o_pay_raddr = ADDR_W'(int'(r_rs) * MAX_SLOT_BYTES + int'(r_idx));
    assign o_pay_wdata = i_data_byte;
    assign o_len_waddr = r_ws;
    assign o_len_raddr = r_rs;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_opcode == OP_RECV && r_count != '0) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                n_state = ST_STREAM;
            end
            ST_STREAM: begin
                if (adv && stream_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctl       = '0;
        o_len_wdata = '0;
        n_ws        = r_ws;
        n_rs        = r_rs;
        n_count     = r_count;
        n_staged    = r_staged;
        n_ovf       = r_ovf;
        n_rlen      = r_rlen;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_byte_sel  = r_byte_sel;
        n_last      = r_last;
        n_out_len   = r_out_len;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_opcode == OP_SEND) begin
                    if (i_byte_present) begin
                        if (fits) begin
                            // bytes sent while full are counted, not written
                            o_ctl.pay_we = !full;
                            n_staged     = r_staged + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    if (i_end_of_message) begin
                        n_out_valid = 1'b1;
                        n_byte_sel  = 1'b0;
                        n_last      = 1'b1;
                        n_out_len   = '0;
                        if (full) begin
                            n_status = STS_FULL;
                        end else if (n_ovf) begin
                            n_status = STS_TOO_LONG;
                        end else begin
                            n_status     = STS_OK;
                            o_ctl.len_we = 1'b1;
                            o_len_wdata  = n_staged;
                            n_out_len    = n_staged;
                            n_ws         = ws_next;
                            n_count      = r_count + 1'b1;
                        end
                        n_staged = '0;
                        n_ovf    = 1'b0;
                    end
                end else if (accept) begin
                    if (r_count == '0) begin
                        n_out_valid = 1'b1;
                        n_status    = STS_EMPTY;
                        n_byte_sel  = 1'b0;
                        n_last      = 1'b1;
                        n_out_len   = '0;
                    end else begin
                        o_ctl.len_re = 1'b1;
                    end
                end
            end
            ST_LEN: begin
                n_rlen = rlen_clamped;
                n_idx  = '0;
            end
            ST_STREAM: begin
                if (adv) begin
                    o_ctl.pay_re = 1'b1;
                    n_out_valid  = 1'b1;
                    n_status     = STS_OK;
                    n_byte_sel   = r_rlen != '0;
                    n_last       = stream_last;
                    n_out_len    = r_rlen;
                    n_idx        = BI_W'(r_idx + 1'b1);
                    if (stream_last) begin
                        n_rs    = rs_next;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ws         <= '0;
            r_rs         <= '0;
            r_count      <= '0;
            r_staged     <= '0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_slot_count <= RST_SLOT_COUNT;
            r_slot_bytes <= RST_SLOT_BYTES;
        end else begin
            r_state     <= n_state;
            r_ws        <= n_ws;
            r_rs        <= n_rs;
            r_count     <= n_count;
            r_staged    <= n_staged;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SLOT_COUNT: r_slot_count <= i_cfg_data[SC_W-1:0];
                    CFG_SLOT_BYTES: r_slot_bytes <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rlen     <= n_rlen;
        r_idx      <= n_idx;
        r_status   <= n_status;
        r_byte_sel <= n_byte_sel;
        r_last     <= n_last;
        r_out_len  <= n_out_len;
    end

    assign o_in_stall       = in_stall;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_out_byte       = r_byte_sel ? i_pay_rdata : 8'd0;
    assign o_out_byte_valid = r_byte_sel;
    assign o_out_last       = r_last;
    assign o_message_length = r_out_len;

    a_len_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LEN |=> r_state == ST_STREAM)
        else $error("length fetch did not move on to streaming");

    a_stream_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STREAM && adv && stream_last) |=> r_state == ST_IDLE)
        else $error("stream did not end after its last transfer");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SLOTS))
        else $error("stored message count above slot capacity");

    a_count_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count < $past(r_count)) |->
            ($past(r_state) == ST_STREAM && $past(r_last) == 1'b1 || $past(r_state) == ST_STREAM))
        else $error("message count dropped outside a receive");

endmodule

### test/message_slot_ring_queue_tb.sv
module message_slot_ring_queue_tb;
    import msrq_pkg::*;

    localparam int MAX_SLOTS      = DEF_MAX_SLOTS;
    localparam int MAX_SLOT_BYTES = DEF_MAX_SLOT_BYTES;
    localparam int STORE_DEPTH    = MAX_SLOTS * MAX_SLOT_BYTES;
    localparam int QUIET_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 6;

    // two copies of the mailbox state: one runs ahead while items are planned,
    // the other follows the transfers the block actually takes
    localparam int GEN = 0;
    localparam int CHK = 1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_mail_item;

    typedef struct packed {
        t_status          status;
        logic [7:0]       out_byte;
        logic             out_byte_valid;
        logic             out_last;
        logic [LEN_W-1:0] message_length;
    } t_mail_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_SLOT_COUNT;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_opcode = OP_SEND;
    logic [7:0]           i_data_byte = 8'd0;
    logic                 i_byte_present = 1'b0;
    logic                 i_end_of_message = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [1:0]           o_status;
    logic [7:0]           o_out_byte;
    logic                 o_out_byte_valid;
    logic                 o_out_last;
    logic [LEN_W-1:0]     o_message_length;

    logic [7:0]       pay_mem   [2][STORE_DEPTH];
    logic [LEN_W-1:0] len_mem   [2][MAX_SLOTS];
    bit               pay_known [STORE_DEPTH];
    int unsigned      wr_ptr    [2];
    int unsigned      rd_ptr    [2];
    logic [SC_W-1:0]  msg_count [2];
    logic [LEN_W-1:0] stage_len [2];
    logic             stage_ovf [2];
    logic [SC_W-1:0]  cfg_slots [2];
    logic [LEN_W-1:0] cfg_bytes [2];

    t_mail_item   request_backlog[$];
    t_mail_result mailbox_replies[$];

    int unsigned idle_pct = 21;
    int unsigned items_planned = 0;
    int unsigned requests_taken = 0;
    int unsigned replies_checked = 0;
    int unsigned fail_count = 0;
    int unsigned quiet_cycles = 0;

    message_slot_ring_queue dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_data_byte      (i_data_byte),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_out_byte       (o_out_byte),
        .o_out_byte_valid (o_out_byte_valid),
        .o_out_last       (o_out_last),
        .o_message_length (o_message_length)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned eff_slots(int w);
        if (cfg_slots[w] == 0) return 1;
        if (cfg_slots[w] > MAX_SLOTS) return MAX_SLOTS;
        return cfg_slots[w];
    endfunction

    function automatic int unsigned eff_bytes(int w);
        return (cfg_bytes[w] > MAX_SLOT_BYTES) ? MAX_SLOT_BYTES : cfg_bytes[w];
    endfunction

    function automatic int unsigned next_slot(int w, int unsigned s);
        return (s + 1 >= eff_slots(w)) ? 0 : s + 1;
    endfunction

    task automatic mailbox_step(input int w, input t_mail_item it);
        bit           full;
        int unsigned  ws;
        int unsigned  rs;
        int unsigned  len;
        t_mail_result r;
        full = msg_count[w] >= eff_slots(w);
        r.status = STS_OK;
        r.out_byte = 8'd0;
        r.out_byte_valid = 1'b0;
        r.out_last = 1'b1;
        r.message_length = '0;
        if (it.opcode == OP_SEND) begin
            ws = wr_ptr[w] % MAX_SLOTS;
            if (it.byte_present) begin
                if (stage_len[w] < eff_bytes(w)) begin
                    // bytes taken while full are counted but never stored
                    if (!full) begin
                        pay_mem[w][ws * MAX_SLOT_BYTES + stage_len[w]] = it.data_byte;
                        if (w == GEN) pay_known[ws * MAX_SLOT_BYTES + stage_len[w]] = 1'b1;
                    end
                    stage_len[w] = stage_len[w] + 1'b1;
                end else begin
                    stage_ovf[w] = 1'b1;
                end
            end
            if (it.end_of_message) begin
                if (full) begin
                    r.status = STS_FULL;
                end else if (stage_ovf[w]) begin
                    r.status = STS_TOO_LONG;
                end else begin
                    len_mem[w][ws] = stage_len[w];
                    wr_ptr[w] = next_slot(w, ws);
                    msg_count[w] = msg_count[w] + 1'b1;
                    r.message_length = stage_len[w];
                end
                stage_len[w] = '0;
                stage_ovf[w] = 1'b0;
                if (w == CHK) mailbox_replies.push_back(r);
            end
        end else if (msg_count[w] == 0) begin
            r.status = STS_EMPTY;
            if (w == CHK) mailbox_replies.push_back(r);
        end else begin
            rs = rd_ptr[w] % MAX_SLOTS;
            len = len_mem[w][rs];
            if (len > MAX_SLOT_BYTES) len = MAX_SLOT_BYTES;
            if (len == 0) begin
                if (w == CHK) mailbox_replies.push_back(r);
            end else if (w == CHK) begin
                for (int i = 0; i < len; i++) begin
                    r.out_byte = pay_mem[w][rs * MAX_SLOT_BYTES + i];
                    r.out_byte_valid = 1'b1;
                    r.out_last = (i + 1 == len);
                    r.message_length = LEN_W'(len);
                    mailbox_replies.push_back(r);
                end
            end
            rd_ptr[w] = next_slot(w, rs);
            msg_count[w] = msg_count[w] - 1'b1;
        end
    endtask

    // A receive in the middle of a send made while full hands the freed slot's
    // old bytes to the new message; allow it only when those bytes are known.
    function automatic bit recv_keeps_known();
        int unsigned base;
        if (stage_len[GEN] == 0 || msg_count[GEN] < eff_slots(GEN)) return 1'b1;
        base = (wr_ptr[GEN] % MAX_SLOTS) * MAX_SLOT_BYTES;
        for (int i = 0; i < stage_len[GEN]; i++)
            if (!pay_known[base + i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_mail_item send_item(logic [7:0] b, logic p, logic e);
        return '{opcode: OP_SEND, data_byte: b, byte_present: p, end_of_message: e};
    endfunction

    function automatic t_mail_item recv_item();
        return '{opcode: OP_RECV, data_byte: 8'($urandom),
                 byte_present: 1'($urandom_range(1)), end_of_message: 1'($urandom_range(1))};
    endfunction

    task automatic queue_item(input t_mail_item it);
        mailbox_step(GEN, it);
        request_backlog.push_back(it);
        items_planned++;
    endtask

    // hold the sender until every reply is back, then let the block go quiet
    task automatic settle();
        do @(negedge i_clk);
        while (request_backlog.size() != 0 || mailbox_replies.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        for (int w = 0; w < 2; w++) begin
            if (idx == CFG_SLOT_COUNT) cfg_slots[w] = val[SC_W-1:0];
            else cfg_bytes[w] = val[LEN_W-1:0];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_traffic(input int unsigned count);
        int unsigned stop_at;
        int unsigned len;
        int unsigned eb;
        int unsigned roll;
        bit          byte_on_last;
        stop_at = items_planned + count;
        while (items_planned < stop_at) begin
            if ($urandom_range(99) < 35) begin
                queue_item(recv_item());
            end else begin
                eb = eff_bytes(GEN);
                roll = $urandom_range(99);
                if (roll < 60) len = $urandom_range((eb < 6) ? eb : 6);
                else if (roll < 85) len = $urandom_range(eb);
                else len = eb + $urandom_range(3, 1);
                byte_on_last = (len != 0) && ($urandom_range(1) == 1);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(99) < 8)
                        queue_item(send_item(8'($urandom), 1'b0, 1'b0));
                    if ($urandom_range(99) < 6 && recv_keeps_known())
                        queue_item(recv_item());
                    queue_item(send_item(8'($urandom), 1'b1, byte_on_last && (i + 1 == len)));
                end
                if (!byte_on_last) queue_item(send_item(8'($urandom), 1'b0, 1'b1));
            end
        end
        // empty the ring so the next slot count starts from aligned pointers
        while (msg_count[GEN] != 0) queue_item(recv_item());
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] slots, input logic [CFG_W-1:0] cap,
                             input int unsigned pct, input int unsigned count);
        settle();
        write_cfg(CFG_SLOT_COUNT, slots);
        write_cfg(CFG_SLOT_BYTES, cap);
        idle_pct = pct;
        random_traffic(count);
    endtask

    always @(posedge i_clk) begin
        bit took;
        took = i_in_valid && !o_in_stall;
        if (took) request_backlog.delete(0);
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (took || !i_in_valid) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_in_valid <= 1'b1;
                i_opcode <= request_backlog[0].opcode;
                i_data_byte <= request_backlog[0].data_byte;
                i_byte_present <= request_backlog[0].byte_present;
                i_end_of_message <= request_backlog[0].end_of_message;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            mailbox_step(CHK, '{opcode: i_opcode, data_byte: i_data_byte,
                                byte_present: i_byte_present,
                                end_of_message: i_end_of_message});
            requests_taken++;
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_mail_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (mailbox_replies.size() == 0) begin
                $error("reply with nothing outstanding: status %0d, byte %0d",
                       o_status, o_out_byte);
                fail_count++;
            end else begin
                want = mailbox_replies.pop_front();
                check_field("status", 8'(want.status), 8'(o_status));
                check_field("out_byte", want.out_byte, o_out_byte);
                check_field("out_byte_valid", 8'(want.out_byte_valid), 8'(o_out_byte_valid));
                check_field("out_last", 8'(want.out_last), 8'(o_out_last));
                check_field("message_length", 8'(want.message_length), 8'(o_message_length));
            end
            replies_checked++;
        end
        i_out_stall <= i_rst_n && ($urandom_range(99) < idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d replies outstanding",
                     quiet_cycles, mailbox_replies.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        for (int w = 0; w < 2; w++) begin
            for (int i = 0; i < STORE_DEPTH; i++) pay_mem[w][i] = 8'd0;
            for (int i = 0; i < MAX_SLOTS; i++) len_mem[w][i] = '0;
            wr_ptr[w] = 0;
            rd_ptr[w] = 0;
            msg_count[w] = '0;
            stage_len[w] = '0;
            stage_ovf[w] = 1'b0;
            cfg_slots[w] = RST_SLOT_COUNT;
            cfg_bytes[w] = RST_SLOT_BYTES;
        end
        for (int i = 0; i < STORE_DEPTH; i++) pay_known[i] = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: empty, zero length, two-byte message with empty closer
        queue_item(recv_item());
        queue_item(send_item(8'h00, 1'b0, 1'b1));
        queue_item(recv_item());
        queue_item(send_item(8'h00, 1'b1, 1'b0));
        queue_item(send_item(8'hFF, 1'b1, 1'b0));
        queue_item(send_item(8'h3C, 1'b0, 1'b1));
        queue_item(recv_item());

        // one slot, no payload allowed: too long, stored, then full
        settle();
        write_cfg(CFG_SLOT_COUNT, 6'd1);
        write_cfg(CFG_SLOT_BYTES, 6'd0);
        queue_item(send_item(8'h5A, 1'b1, 1'b1));
        queue_item(send_item(8'h00, 1'b0, 1'b1));
        queue_item(send_item(8'h00, 1'b0, 1'b1));
        queue_item(recv_item());

        // cap above range; send while full, free the slot before the last item
        settle();
        write_cfg(CFG_SLOT_BYTES, 6'd63);
        queue_item(send_item(8'h11, 1'b1, 1'b0));
        queue_item(send_item(8'h22, 1'b1, 1'b0));
        queue_item(send_item(8'h33, 1'b1, 1'b0));
        queue_item(send_item(8'h44, 1'b1, 1'b1));
        queue_item(send_item(8'h77, 1'b1, 1'b0));
        queue_item(send_item(8'h88, 1'b1, 1'b0));
        queue_item(send_item(8'h99, 1'b1, 1'b0));
        queue_item(recv_item());
        queue_item(send_item(8'h00, 1'b0, 1'b1));
        queue_item(recv_item());

        // shrink the ring with two messages stored, then realign the pointers
        settle();
        write_cfg(CFG_SLOT_COUNT, 6'd4);
        queue_item(send_item(8'hA1, 1'b1, 1'b1));
        queue_item(send_item(8'hB2, 1'b1, 1'b1));
        settle();
        write_cfg(CFG_SLOT_COUNT, 6'd1);
        queue_item(recv_item());
        queue_item(recv_item());
        queue_item(send_item(8'hC3, 1'b1, 1'b1));
        queue_item(recv_item());

        run_phase(6'd16, 6'd32, 21, 80);
        run_phase(6'd3, 6'd5, 0, 70);
        run_phase(6'd0, 6'd12, 21, 70);
        run_phase(6'd31, 6'($urandom_range(40, 1)), 21, 60);
        settle();

        $display("%0d requests and %0d replies across slot counts 0 to 31 and caps 0 to 63,",
                 requests_taken, replies_checked);
        $display("including empty, full, too long, zero length and ring resize cases");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
